@@ design/upsd_pkg.sv @@
package upsd_pkg;

   localparam int unsigned COUNT_BITS = 16;
   localparam int unsigned CMP_BITS   = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 2;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [7:0]  CH_PERCENT   = 8'h25;
   localparam logic [7:0]  CH_SLASH     = 8'h2F;
   localparam logic [7:0]  CH_NUL       = 8'h00;
   localparam logic [15:0] CAP_RESET    = 16'd256;
   localparam logic [15:0] REPORT_MAX   = 16'hFFFF;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_PCT   = 3'b010,
      PH_DIGIT = 3'b100
   } phase_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        is_last;
      logic        ended_on_slash;
      logic [15:0] stored_count;
      logic [15:0] consumed_count;
   } rsp_type;

   // {valid, nibble}
   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [4:0] r;
      r = 5'b0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

   function automatic logic [15:0] report_sat(input logic [COUNT_BITS-1:0] v);
      logic [15:0] r;
      if (CMP_BITS'(v) > CMP_BITS'(REPORT_MAX)) begin
         r = REPORT_MAX;
      end else begin
         r = 16'(v);
      end
      return r;
   endfunction

   function automatic rsp_type data_item(input logic [7:0] b);
      rsp_type r;
      r = '0;
      r.out_byte = b;
      return r;
   endfunction

endpackage

@@ design/url_percent_segment_decoder.sv @@
// A transaction's first result is registered and shown in the cycle after acceptance.
// Throughput: one byte per cycle while each byte yields at most one result and
// rsp_ready is high; a byte that yields two or three results holds the input
// while the three-entry result buffer drains.
// Reset (synchronous): escape state and counters clear, capacity returns to 256,
// result buffer empties.
module url_percent_segment_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_last,
   output logic        rsp_ended_on_slash,
   output logic [15:0] rsp_stored_count,
   output logic [15:0] rsp_consumed_count,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   localparam int unsigned CB = upsd_pkg::COUNT_BITS;
   localparam int unsigned WB = upsd_pkg::CMP_BITS;

   logic [15:0]          cap_ff;
   upsd_pkg::phase_type  phase_ff, phase_in;
   logic [7:0]           held_ff, held_in;
   logic [CB-1:0]        stored_ff, stored_in;
   logic [CB-1:0]        consumed_ff, consumed_in;
   upsd_pkg::rsp_type    slot_ff [3];
   upsd_pkg::rsp_type    slot_in [3];
   logic [1:0]           pend_ff, pend_in;

   logic                 accept, pop;
   logic                 term;
   logic [4:0]           hx_cur, hx_held;
   logic [7:0]           att [3];
   logic [1:0]           n_att;
   logic [2:0]           ok;
   logic [1:0]           n_emit;
   logic [WB-1:0]        s_ext;
   upsd_pkg::rsp_type    summary;

   assign rsp_valid = (pend_ff != 2'd0);
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = (pend_ff == 2'd0) || ((pend_ff == 2'd1) && rsp_ready);
   assign accept    = req_valid && req_ready;

   assign rsp_out_byte       = slot_ff[0].out_byte;
   assign rsp_is_last        = slot_ff[0].is_last;
   assign rsp_ended_on_slash = slot_ff[0].ended_on_slash;
   assign rsp_stored_count   = slot_ff[0].stored_count;
   assign rsp_consumed_count = slot_ff[0].consumed_count;

   assign term    = (req_in_byte == upsd_pkg::CH_NUL) || (req_in_byte == upsd_pkg::CH_SLASH);
   assign hx_cur  = upsd_pkg::hex_decode(req_in_byte);
   assign hx_held = upsd_pkg::hex_decode(held_ff);
   assign s_ext   = WB'(stored_ff);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ok[k] = ((s_ext + WB'(k)) < WB'(upsd_pkg::COUNT_MAX)) &&
                 ((s_ext + WB'(k + 1)) < WB'(cap_ff));
      end
   end

   // build the list of byte emit attempts and the next escape state for this transaction
   always_comb begin
      att[0]   = req_in_byte;
      att[1]   = req_in_byte;
      att[2]   = req_in_byte;
      n_att    = 2'd0;
      phase_in = upsd_pkg::PH_IDLE;
      held_in  = 8'h00;
      unique case (phase_ff)
         upsd_pkg::PH_DIGIT: begin
            if (term) begin
               att[0] = upsd_pkg::CH_PERCENT;
               att[1] = held_ff;
               n_att  = 2'd2;
            end else if (hx_cur[4]) begin
               att[0] = {hx_held[3:0], hx_cur[3:0]};
               n_att  = 2'd1;
            end else begin
               att[0] = upsd_pkg::CH_PERCENT;
               att[1] = held_ff;
               if (req_in_byte == upsd_pkg::CH_PERCENT) begin
                  n_att    = 2'd2;
                  phase_in = upsd_pkg::PH_PCT;
               end else begin
                  n_att = 2'd3;
               end
            end
         end
         upsd_pkg::PH_PCT: begin
            if (term) begin
               att[0] = upsd_pkg::CH_PERCENT;
               n_att  = 2'd1;
            end else if (hx_cur[4]) begin
               phase_in = upsd_pkg::PH_DIGIT;
               held_in  = req_in_byte;
            end else begin
               att[0] = upsd_pkg::CH_PERCENT;
               if (req_in_byte == upsd_pkg::CH_PERCENT) begin
                  n_att    = 2'd1;
                  phase_in = upsd_pkg::PH_PCT;
               end else begin
                  n_att = 2'd2;
               end
            end
         end
         default: begin
            if (term) begin
               n_att = 2'd0;
            end else if (req_in_byte == upsd_pkg::CH_PERCENT) begin
               phase_in = upsd_pkg::PH_PCT;
            end else begin
               n_att = 2'd1;
            end
         end
      endcase
   end

   assign n_emit = 2'((n_att >= 2'd1) && ok[0]) + 2'((n_att >= 2'd2) && ok[1]) +
                   2'((n_att == 2'd3) && ok[2]);

   always_comb begin
      summary                = '0;
      summary.is_last        = 1'b1;
      summary.ended_on_slash = (req_in_byte == upsd_pkg::CH_SLASH);
      summary.stored_count   = upsd_pkg::report_sat(CB'(s_ext + WB'(n_emit)));
      summary.consumed_count = upsd_pkg::report_sat(consumed_ff);
   end

   always_comb begin
      stored_in   = term ? '0 : CB'(s_ext + WB'(n_emit));
      consumed_in = consumed_ff;
      if (term) begin
         consumed_in = '0;
      end else if (consumed_ff != upsd_pkg::COUNT_MAX) begin
         consumed_in = consumed_ff + CB'(1);
      end
   end

   always_comb begin
      slot_in[0] = slot_ff[1];
      slot_in[1] = slot_ff[2];
      slot_in[2] = slot_ff[2];
      pend_in    = pend_ff;
      if (accept) begin
         for (int i = 0; i < 3; i++) begin
            if (2'(i) < n_emit) begin
               slot_in[i] = upsd_pkg::data_item(att[i]);
            end else begin
               slot_in[i] = summary;
            end
         end
         pend_in = n_emit + 2'(term);
      end else if (pop) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff      <= upsd_pkg::CAP_RESET;
         phase_ff    <= upsd_pkg::PH_IDLE;
         held_ff     <= 8'h00;
         stored_ff   <= '0;
         consumed_ff <= '0;
         pend_ff     <= 2'd0;
      end else begin
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
         if (accept) begin
            phase_ff    <= phase_in;
            held_ff     <= held_in;
            stored_ff   <= stored_in;
            consumed_ff <= consumed_in;
         end
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept || pop) begin
         for (int i = 0; i < 3; i++) begin
            slot_ff[i] <= slot_in[i];
         end
      end
   end

   a_pend_hold: assert property (@(posedge clock) disable iff (reset)
      (!accept && !pop) |=> (pend_ff == $past(pend_ff)))
      else $error("result buffer count changed without a transaction");

   a_accept_drained: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> (pend_ff == 2'd0 || (pend_ff == 2'd1 && rsp_ready)))
      else $error("transaction accepted while results pending");

   a_data_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_last) |->
         (rsp_stored_count == 16'd0 && rsp_consumed_count == 16'd0 && !rsp_ended_on_slash))
      else $error("data item carries summary fields");

   a_summary_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_last) |-> (rsp_out_byte == 8'h00))
      else $error("summary item carries a data byte");

   a_held_digit: assert property (@(posedge clock) disable iff (reset)
      (held_ff != 8'h00) |-> (phase_ff == upsd_pkg::PH_DIGIT && hx_held[4]))
      else $error("held digit without digit phase");

endmodule
